// File: src/csl_pkg.sv
// Shared types and constants for the cascaded shift low-pass filter.
package csl_pkg;

   localparam int DATA_W   = 32;
   localparam int SAMPLE_W = 16;
   localparam int SHIFT_W  = 4;
   localparam int COUNT_W  = 3;
   localparam int CSR_W    = 32;
   localparam int ADDR_W   = 4;

   localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd6;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd12;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd6;
   localparam logic [COUNT_W-1:0] POLES_RESET = 3'd1;

   typedef enum logic [1:0] {
      REG_FILTER_ENABLED = 2'd0,
      REG_SHIFT_AMOUNT   = 2'd1,
      REG_POLE_COUNT     = 2'd2
   } csl_reg_type;

   // Settings the back end needs while it works through the poles.
   typedef struct packed {
      logic [SHIFT_W-1:0] shift_amount;
      logic [COUNT_W-1:0] pole_count;
   } csl_cfg_type;

   // One classified sample waiting for the back end.
   typedef struct packed {
      logic [DATA_W-1:0] scaled;
      logic              bypass;
   } csl_item_type;

endpackage

// File: src/csl_if.sv
// Handshake channel interfaces for samples and filter results.
interface csl_req_if;
   logic        valid;
   logic        ready;
   logic signed [csl_pkg::SAMPLE_W-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink (input valid, input adc_sample, output ready);
endinterface

interface csl_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [csl_pkg::DATA_W-1:0] filtered_value;
   logic        applied_ok;

   modport source (output valid, output filtered_value, output applied_ok, input ready);
   modport sink (input valid, input filtered_value, input applied_ok, output ready);
endinterface

// File: src/csl_front.sv
// Front end: register file, sample scaling and bypass classification.
module csl_front #(
   parameter int FRACTION_BITS = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [csl_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [csl_pkg::CSR_W-1:0]    csr_pwdata,
   output logic [csl_pkg::CSR_W-1:0]    csr_prdata,
   output logic                         csr_pready,
   csl_req_if.sink                      req,
   output logic                         item_valid,
   input  logic                         item_ready,
   output csl_pkg::csl_item_type        item,
   output csl_pkg::csl_cfg_type         cfg
);
   import csl_pkg::*;

   logic               enabled_ff, enabled_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [COUNT_W-1:0] poles_ff, poles_in;
   logic               valid_ff, valid_in;
   csl_item_type       item_ff, item_in;
   logic               wr_en;
   csl_reg_type        reg_sel;
   logic [DATA_W-1:0]  scaled;

   assign reg_sel    = csl_reg_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      enabled_in = enabled_ff;
      shift_in   = shift_ff;
      poles_in   = poles_ff;
      csr_prdata = '0;
      unique case (reg_sel)
         REG_FILTER_ENABLED: begin
            csr_prdata = CSR_W'(enabled_ff);
            if (wr_en) enabled_in = csr_pwdata[0];
         end
         REG_SHIFT_AMOUNT: begin
            csr_prdata = CSR_W'(shift_ff);
            if (wr_en) shift_in = csr_pwdata[SHIFT_W-1:0];
         end
         REG_POLE_COUNT: begin
            csr_prdata = CSR_W'(poles_ff);
            if (wr_en) poles_in = csr_pwdata[COUNT_W-1:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   assign scaled = DATA_W'(req.adc_sample) << FRACTION_BITS;

   assign req.ready = !valid_ff || item_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req.valid && req.ready) begin
         valid_in       = 1'b1;
         item_in.scaled = scaled;
         // out-of-range shift counts as not configured
         item_in.bypass = !enabled_ff || (shift_ff < SHIFT_MIN) || (shift_ff > SHIFT_MAX);
      end else if (item_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         shift_ff   <= SHIFT_RESET;
         poles_ff   <= POLES_RESET;
         valid_ff   <= 1'b0;
      end else begin
         enabled_ff <= enabled_in;
         shift_ff   <= shift_in;
         poles_ff   <= poles_in;
         valid_ff   <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid       = valid_ff;
   assign item             = item_ff;
   assign cfg.shift_amount = shift_ff;
   assign cfg.pole_count   = poles_ff;

endmodule

// File: src/csl_queue.sv
// Two-entry queue between the front end and the pole engine.
module csl_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  csl_pkg::csl_item_type push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output csl_pkg::csl_item_type pop_data
);
   import csl_pkg::*;

   csl_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

endmodule

// File: src/csl_back.sv
// Pole engine: runs each pole through a subtract state and an add state, and holds the result register.
module csl_back #(
   parameter int MAX_POLES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  csl_pkg::csl_cfg_type  cfg,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  csl_pkg::csl_item_type item,
   csl_rsp_if.source             rsp
);
   import csl_pkg::*;

   localparam int CNT_W = $clog2(MAX_POLES + 1);
   localparam int IDX_W = (MAX_POLES > 1) ? $clog2(MAX_POLES) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUB,
      ST_ADD,
      ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [DATA_W-1:0] scaled_ff, scaled_in;
   logic [DATA_W-1:0] cur_ff, cur_in;
   logic [DATA_W-1:0] lag_ff, lag_in;
   logic [DATA_W-1:0] res_val_ff, res_val_in;
   logic              res_ok_ff, res_ok_in;
   logic              pending_ff, pending_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_val_ff, rsp_val_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [DATA_W-1:0] pole_ff [MAX_POLES];
   logic [DATA_W-1:0] pole_in [MAX_POLES];

   logic [DATA_W-1:0] pole_rd, diff, shifted, sum;
   logic              sub_ovf, add_ovf, last;

   assign item_ready = (state_ff == ST_IDLE);

   assign pole_rd = pole_ff[idx_ff];
   assign diff    = cur_ff - pole_rd;
   assign sub_ovf = (cur_ff[DATA_W-1] ^ pole_rd[DATA_W-1]) & (cur_ff[DATA_W-1] ^ diff[DATA_W-1]);
   assign shifted = DATA_W'($signed(lag_ff) >>> cfg.shift_amount);
   assign sum     = pole_rd + shifted;
   assign add_ovf = ~(pole_rd[DATA_W-1] ^ shifted[DATA_W-1]) & (pole_rd[DATA_W-1] ^ sum[DATA_W-1]);
   assign last    = (CNT_W'(idx_ff) + CNT_W'(1)) == n_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      scaled_in    = scaled_ff;
      cur_in       = cur_ff;
      lag_in       = lag_ff;
      res_val_in   = res_val_ff;
      res_ok_in    = res_ok_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_val_in   = rsp_val_ff;
      rsp_ok_in    = rsp_ok_ff;
      pole_in      = pole_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               scaled_in = item.scaled;
               cur_in    = item.scaled;
               idx_in    = '0;
               n_in      = (8'(cfg.pole_count) > 8'(MAX_POLES)) ? CNT_W'(MAX_POLES)
                                                                : CNT_W'(cfg.pole_count);
               res_val_in = item.scaled;
               res_ok_in  = 1'b1;
               if (item.bypass) begin
                  res_ok_in = 1'b0;
                  state_in  = ST_OUT;
               end else if (pending_ff) begin
                  // restart: every pole takes the sample, which passes through
                  for (int i = 0; i < MAX_POLES; i++) pole_in[i] = item.scaled;
                  pending_in = 1'b0;
                  state_in   = ST_OUT;
               end else if (cfg.pole_count == '0) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_SUB;
               end
            end
         end
         ST_SUB: begin
            if (sub_ovf) begin
               res_val_in = scaled_ff;
               res_ok_in  = 1'b0;
               pending_in = 1'b1;
               state_in   = ST_OUT;
            end else begin
               lag_in   = diff;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (add_ovf) begin
               res_val_in = scaled_ff;
               res_ok_in  = 1'b0;
               pending_in = 1'b1;
               state_in   = ST_OUT;
            end else begin
               pole_in[idx_ff] = sum;
               cur_in          = sum;
               if (last) begin
                  res_val_in = sum;
                  res_ok_in  = 1'b1;
                  state_in   = ST_OUT;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_SUB;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = res_val_ff;
               rsp_ok_in    = res_ok_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff     <= idx_in;
      n_ff       <= n_in;
      scaled_ff  <= scaled_in;
      cur_ff     <= cur_in;
      lag_ff     <= lag_in;
      res_val_ff <= res_val_in;
      res_ok_ff  <= res_ok_in;
      rsp_val_ff <= rsp_val_in;
      rsp_ok_ff  <= rsp_ok_in;
      pole_ff    <= pole_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.filtered_value = rsp_val_ff;
   assign rsp.applied_ok     = rsp_ok_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUB || state_ff == ST_ADD) |-> (CNT_W'(idx_ff) < n_ff))
      else $error("pole index beyond active pole count");

   a_restart_on_fail: assert property (@(posedge clock) disable iff (reset)
      ($rose(pending_ff) && !$past(reset)) |->
         ($past(state_ff) == ST_SUB || $past(state_ff) == ST_ADD))
      else $error("restart raised outside pole processing");

   a_fail_not_ok: assert property (@(posedge clock) disable iff (reset)
      ($rose(pending_ff) && !$past(reset)) |-> (state_ff == ST_OUT && !res_ok_ff))
      else $error("overflow did not produce a failed result");

endmodule

// File: src/cascaded_shift_lowpass_filter.sv
// A sample passes the front-end item register and the queue to the pole engine. In bypass or
// restart it goes from idle to output; filtering runs a subtract and an add state per pole.
// The single subtract/shift/add pole engine takes no new sample until idle and sets the rate.
// Reset (synchronous, active high): filter disabled, shift 6, one pole, restart pending,
// queue and output empty. Pole values are undefined until the first restart loads them.
module cascaded_shift_lowpass_filter #(
   parameter int MAX_POLES     = 4,
   parameter int FRACTION_BITS = 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [csl_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [csl_pkg::CSR_W-1:0]  csr_pwdata,
   output logic [csl_pkg::CSR_W-1:0]  csr_prdata,
   output logic                       csr_pready,
   csl_req_if.sink                    req,
   csl_rsp_if.source                  rsp
);
   import csl_pkg::*;

   logic         front_valid, front_ready;
   csl_item_type front_item;
   logic         back_valid, back_ready;
   csl_item_type back_item;
   csl_cfg_type  cfg;

   csl_front #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .req        (req),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item),
      .cfg        (cfg)
   );

   csl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(front_valid),
      .push_ready(front_ready),
      .push_data (front_item),
      .pop_valid (back_valid),
      .pop_ready (back_ready),
      .pop_data  (back_item)
   );

   csl_back #(
      .MAX_POLES(MAX_POLES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .item_valid(back_valid),
      .item_ready(back_ready),
      .item      (back_item),
      .rsp       (rsp)
   );

endmodule
